FILE: rtl/core/coct_pkg.sv
package coct_pkg;

  // Device count and field widths
  localparam int unsigned NumDevices = 3;
  localparam int unsigned CmdW       = 2;
  localparam int unsigned DevW       = 2;
  localparam int unsigned CharW      = 8;
  localparam int unsigned ColW       = 16;
  localparam int unsigned StepW      = 3;

  // Command codes
  localparam logic [CmdW-1:0] CmdPlain  = 2'd0;
  localparam logic [CmdW-1:0] CmdTab    = 2'd1;
  localparam logic [CmdW-1:0] CmdCooked = 2'd2;

  // Character codes
  localparam logic [CharW-1:0] ChBs      = 8'h08;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChCr      = 8'h0d;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChCaret   = 8'h5e;
  localparam logic [CharW-1:0] CaretBit  = 8'h40;

  // Last step of a tab expansion (eight spaces at most)
  localparam logic [StepW-1:0] StepMax = 3'd7;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dev_ok;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/coct_if.sv
interface coct_in_if;
  logic                             valid;
  logic                             ready;
  logic [coct_pkg::CmdW-1:0]        command;
  logic [coct_pkg::DevW-1:0]        device;
  logic [coct_pkg::CharW-1:0]       char_in;

  modport source (output valid, output command, output device, output char_in, input ready);
  modport sink   (input valid, input command, input device, input char_in, output ready);
endinterface

interface coct_out_if;
  logic                             valid;
  logic                             ready;
  logic [coct_pkg::CharW-1:0]       char_out;
  logic [coct_pkg::DevW-1:0]        device_out;
  logic signed [coct_pkg::ColW-1:0] column_after;
  logic                             last;

  modport source (output valid, output char_out, output device_out, output column_after,
                  output last, input ready);
  modport sink   (input valid, input char_out, input device_out, input column_after,
                  input last, output ready);
endinterface

FILE: rtl/core/coct_ctrl.sv
module coct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  coct_pkg::dp_status_t status_i,
  output coct_pkg::dp_cmd_t    cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;

  // Take a new item only when no item is in flight
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.emit = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StEmit;
        end
      end
      StEmit: begin
        // Drop items for unknown devices, else send one byte per free slot
        if (!status_i.dev_ok) begin
          state_d = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/coct_dp.sv
module coct_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [coct_pkg::CmdW-1:0]         command_i,
  input  logic [coct_pkg::DevW-1:0]         device_i,
  input  logic [coct_pkg::CharW-1:0]        char_in_i,
  input  coct_pkg::dp_cmd_t                 cmd_i,
  output coct_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [coct_pkg::CharW-1:0]        char_out_o,
  output logic [coct_pkg::DevW-1:0]         device_out_o,
  output logic signed [coct_pkg::ColW-1:0]  column_after_o,
  output logic                              last_o
);

  logic [coct_pkg::CmdW-1:0]  cmd_q;
  logic [coct_pkg::DevW-1:0]  dev_q;
  logic [coct_pkg::CharW-1:0] ch_q;
  logic [coct_pkg::StepW-1:0] step_q;
  logic [coct_pkg::ColW-1:0]  column_q [coct_pkg::NumDevices];

  logic                       out_valid_q;
  logic [coct_pkg::CharW-1:0] out_char_q;
  logic [coct_pkg::DevW-1:0]  out_dev_q;
  logic [coct_pkg::ColW-1:0]  out_col_q;
  logic                       out_last_q;

  logic                       dev_ok;
  logic                       is_tab;
  logic                       is_caret;
  logic [coct_pkg::CharW-1:0] byte_d;
  logic [coct_pkg::ColW-1:0]  col_cur;
  logic [coct_pkg::ColW-1:0]  col_d;
  logic                       last_d;

  // Decode the held item
  always_comb begin
    dev_ok   = (32'(dev_q) < coct_pkg::NumDevices);
    is_tab   = ((cmd_q == coct_pkg::CmdTab) || (cmd_q == coct_pkg::CmdCooked)) &&
               (ch_q == coct_pkg::ChTab);
    is_caret = (cmd_q == coct_pkg::CmdCooked) && (ch_q < coct_pkg::ChSpace) && !is_tab;
    col_cur  = dev_ok ? column_q[dev_q] : '0;
  end

  // Pick the byte for this step
  always_comb begin
    priority if (is_tab) begin
      byte_d = coct_pkg::ChSpace;
    end else if (is_caret) begin
      byte_d = (step_q == '0) ? coct_pkg::ChCaret : (ch_q | coct_pkg::CaretBit);
    end else begin
      byte_d = ch_q;
    end
  end

  // Column after the byte
  always_comb begin
    priority if (byte_d >= coct_pkg::ChSpace) begin
      col_d = col_cur + coct_pkg::ColW'(1);
    end else if (byte_d == coct_pkg::ChCr) begin
      col_d = '0;
    end else if (byte_d == coct_pkg::ChBs) begin
      col_d = col_cur - coct_pkg::ColW'(1);
    end else begin
      col_d = col_cur;
    end
  end

  // Tabs stop at a multiple of eight or after eight spaces
  always_comb begin
    priority if (is_tab) begin
      last_d = (col_d[2:0] == 3'd0) || (step_q == coct_pkg::StepMax);
    end else if (is_caret) begin
      last_d = (step_q != '0);
    end else begin
      last_d = 1'b1;
    end
  end

  assign status_o.dev_ok    = dev_ok;
  assign status_o.emit_last = last_d;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      dev_q <= device_i;
      ch_q  <= char_in_i;
    end
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.emit) begin
      step_q <= step_q + coct_pkg::StepW'(1);
    end
  end

  // Per-device column counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < coct_pkg::NumDevices; i++) begin
        column_q[i] <= '0;
      end
    end else if (cmd_i.emit) begin
      for (int i = 0; i < coct_pkg::NumDevices; i++) begin
        if (32'(dev_q) == i) begin
          column_q[i] <= col_d;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= byte_d;
      out_dev_q  <= dev_q;
      out_col_q  <= col_d;
      out_last_q <= last_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign char_out_o     = out_char_q;
  assign device_out_o   = out_dev_q;
  assign column_after_o = $signed(out_col_q);
  assign last_o         = out_last_q;

endmodule

FILE: rtl/core/console_output_column_tracker.sv
// Console output column tracker: one item (command, device, char_in) yields one to eight
// output bytes, each with the device column after it and a last flag on the final one.
// An item is accepted and then the emit sequencer sends one byte per cycle, while the
// output side keeps up, into a single output register; a stalled output holds the
// sequencer. An item for an unknown device is dropped and gives nothing. A new item is
// taken only once the previous one has placed its last byte in the output register.
module console_output_column_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  coct_in_if.sink     in_i,
  coct_out_if.source  out_o
);

  coct_pkg::dp_cmd_t    dp_cmd;
  coct_pkg::dp_status_t dp_status;

  coct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  coct_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .command_i      (in_i.command),
    .device_i       (in_i.device),
    .char_in_i      (in_i.char_in),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .char_out_o     (out_o.char_out),
    .device_out_o   (out_o.device_out),
    .column_after_o (out_o.column_after),
    .last_o         (out_o.last)
  );

endmodule

FILE: rtl/core/coct_checker.sv
module coct_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [coct_pkg::CharW-1:0]        char_out_i,
  input logic signed [coct_pkg::ColW-1:0]  column_after_i,
  input logic                              last_i
);

  logic in_fire;
  logic out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // One item at a time: ready drops after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !in_ready_i)
    else $error("input accepted while an item is in flight");

  // Ready stays low while a byte other than the last one waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_i && !last_i |-> !in_ready_i)
    else $error("new item taken before the last byte");

  // Only a space or a caret can precede further bytes of the same item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_i && !last_i |->
                   (char_out_i == coct_pkg::ChSpace) || (char_out_i == coct_pkg::ChCaret))
    else $error("unexpected byte before the last one");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_i && !out_ready_i |=>
                   out_valid_i && $stable(char_out_i) && $stable(column_after_i) &&
                   $stable(last_i))
    else $error("stalled result changed");

endmodule

bind console_output_column_tracker coct_checker u_coct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .char_out_i     (out_o.char_out),
  .column_after_i (out_o.column_after),
  .last_i         (out_o.last)
);

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import coct_pkg::*;

  // Command code 3 has no meaning of its own and falls back to plain output
  localparam logic [CmdW-1:0] CmdSpare = 2'd3;
  localparam logic [DevW-1:0] DevNone  = DevW'(NumDevices);

  localparam int unsigned RandomItems = 96;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned CycleLimit  = 400000;

  // One byte sent to a device
  typedef struct packed {
    logic [CharW-1:0]       ch;
    logic [DevW-1:0]        dev;
    logic signed [ColW-1:0] col;
    logic                   last;
  } tty_byte_t;

  // Directed item; when typed is set, the byte count and the final byte are known up front
  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic [DevW-1:0]        dev;
    logic [CharW-1:0]       ch;
    logic                   typed;
    logic [3:0]             n_bytes;
    logic [CharW-1:0]       last_ch;
    logic signed [ColW-1:0] last_col;
  } dir_row_t;

  // Rows run from reset, so every column starts at zero
  localparam dir_row_t DirectedRows [25] = '{
    '{CmdPlain,  2'd0,    8'h41, 1'b1, 4'd1, 8'h41, 16'sd1},
    '{CmdTab,    2'd0,    ChTab, 1'b1, 4'd7, 8'h20, 16'sd8},
    '{CmdTab,    2'd0,    ChTab, 1'b1, 4'd8, 8'h20, 16'sd16},
    '{CmdCooked, 2'd0,    ChCr,  1'b1, 4'd2, 8'h4d, 16'sd18},
    '{CmdPlain,  2'd0,    ChCr,  1'b1, 4'd1, ChCr,  16'sd0},
    '{CmdPlain,  2'd0,    ChBs,  1'b1, 4'd1, ChBs,  -16'sd1},
    '{CmdTab,    2'd0,    ChTab, 1'b1, 4'd1, 8'h20, 16'sd0},
    '{CmdPlain,  2'd0,    ChBs,  1'b1, 4'd1, ChBs,  -16'sd1},
    '{CmdCooked, 2'd0,    ChBs,  1'b1, 4'd2, 8'h48, 16'sd1},
    '{CmdSpare,  2'd1,    ChTab, 1'b1, 4'd1, ChTab, 16'sd0},
    '{CmdPlain,  DevNone, 8'hff, 1'b1, 4'd0, 8'h00, 16'sd0},
    '{CmdPlain,  2'd2,    8'hff, 1'b1, 4'd1, 8'hff, 16'sd1},
    '{CmdPlain,  2'd2,    8'h00, 1'b1, 4'd1, 8'h00, 16'sd1},
    '{CmdCooked, 2'd2,    8'h00, 1'b1, 4'd2, 8'h40, 16'sd3},
    '{CmdCooked, 2'd2,    8'h1f, 1'b1, 4'd2, 8'h5f, 16'sd5},
    '{CmdCooked, 2'd2,    8'h20, 1'b1, 4'd1, 8'h20, 16'sd6},
    '{CmdTab,    2'd1,    8'h41, 1'b1, 4'd1, 8'h41, 16'sd1},
    '{CmdCooked, 2'd1,    ChTab, 1'b0, 4'd0, 8'h00, 16'sd0},
    '{CmdTab,    2'd1,    ChCr,  1'b1, 4'd1, ChCr,  16'sd0},
    '{CmdCooked, DevNone, ChTab, 1'b1, 4'd0, 8'h00, 16'sd0},
    '{CmdCooked, 2'd2,    8'h7f, 1'b1, 4'd1, 8'h7f, 16'sd7},
    '{CmdPlain,  2'd1,    8'h80, 1'b1, 4'd1, 8'h80, 16'sd1},
    '{CmdTab,    2'd2,    ChTab, 1'b0, 4'd0, 8'h00, 16'sd0},
    '{CmdSpare,  2'd2,    ChBs,  1'b0, 4'd0, 8'h00, 16'sd0},
    '{CmdTab,    2'd1,    ChBs,  1'b0, 4'd0, 8'h00, 16'sd0}
  };

  logic clk_i;
  logic rst_ni;

  coct_in_if  in_bus ();
  coct_out_if out_bus ();

  console_output_column_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Predicted state and pending bytes
  logic [ColW-1:0] dev_column [NumDevices];
  tty_byte_t       pending_bytes [$];

  int          errors;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          phase;
  int unsigned hold_left;
  bit          hold_done;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Advance one device column for a byte and queue the byte
  task automatic send_byte(input logic [DevW-1:0] dev, input logic [CharW-1:0] ch);
    tty_byte_t b;
    if (ch >= ChSpace) begin
      dev_column[dev] = dev_column[dev] + 1'b1;
    end else if (ch == ChCr) begin
      dev_column[dev] = '0;
    end else if (ch == ChBs) begin
      dev_column[dev] = dev_column[dev] - 1'b1;
    end
    b.ch   = ch;
    b.dev  = dev;
    b.col  = dev_column[dev];
    b.last = 1'b0;
    pending_bytes.push_back(b);
  endtask

  // Work out the bytes that one item sends; mark the final one
  task automatic predict_output(input logic [CmdW-1:0] cmd, input logic [DevW-1:0] dev,
                                input logic [CharW-1:0] ch, output int n,
                                output tty_byte_t tail);
    n    = 0;
    tail = '0;
    if (dev >= NumDevices) return;
    if ((cmd == CmdTab || cmd == CmdCooked) && ch == ChTab) begin
      do begin
        send_byte(dev, ChSpace);
        n++;
      end while (dev_column[dev][2:0] != 3'd0 && n < 8);
    end else if (cmd == CmdCooked && ch < ChSpace) begin
      send_byte(dev, ChCaret);
      send_byte(dev, ch | CaretBit);
      n = 2;
    end else begin
      send_byte(dev, ch);
      n = 1;
    end
    tail = pending_bytes.pop_back();
    tail.last = 1'b1;
    pending_bytes.push_back(tail);
  endtask

  // Offer one item, wait for acceptance, then predict its bytes
  task automatic offer_item(input logic [CmdW-1:0] cmd, input logic [DevW-1:0] dev,
                            input logic [CharW-1:0] ch, output int n, output tty_byte_t tail);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.command <= cmd;
    in_bus.device  <= dev;
    in_bus.char_in <= ch;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_output(cmd, dev, ch, n, tail);
  endtask

  // Receiver: random stalls, plus one long hold at the start of the last phase
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == 2 && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each byte taken with the oldest pending one
  always @(posedge clk_i) begin : check_bytes
    tty_byte_t want;
    tty_byte_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.ch   = out_bus.char_out;
      got.dev  = out_bus.device_out;
      got.col  = out_bus.column_after;
      got.last = out_bus.last;
      if (pending_bytes.size() == 0) begin
        $display("%0t: byte with none pending: ch=%h dev=%0d col=%0d last=%b",
                 $time, got.ch, got.dev, got.col, got.last);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (got.ch !== want.ch || got.dev !== want.dev || got.col !== want.col ||
            got.last !== want.last) begin
          $display("%0t: expected ch=%h dev=%0d col=%0d last=%b,",
                   $time, want.ch, want.dev, want.col, want.last,
                   " got ch=%h dev=%0d col=%0d last=%b",
                   got.ch, got.dev, got.col, got.last);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("console_output_column_tracker: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CmdW-1:0]  cmd;
    logic [DevW-1:0]  dev;
    logic [CharW-1:0] ch;
    int               n;
    int unsigned      pick;
    tty_byte_t        tail;
    dir_row_t         row;

    in_bus.valid   = 1'b0;
    in_bus.command = CmdPlain;
    in_bus.device  = '0;
    in_bus.char_in = '0;
    errors         = 0;
    cycle_count    = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    phase          = 0;
    send_idle_pct  = 19;
    recv_idle_pct  = 48;
    for (int d = 0; d < NumDevices; d++) dev_column[d] = '0;

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items: extremes, every command, control bytes, tab stops, ignored devices
    for (int i = 0; i < $size(DirectedRows); i++) begin
      row = DirectedRows[i];
      offer_item(row.cmd, row.dev, row.ch, n, tail);
      if (row.typed && (n != int'(row.n_bytes) ||
          (n != 0 && (tail.ch != row.last_ch || tail.col != row.last_col)))) begin
        $display("%0t: row %0d expected %0d bytes ending ch=%h col=%0d,",
                 $time, i, row.n_bytes, row.last_ch, row.last_col,
                 " got %0d ending ch=%h col=%0d", n, tail.ch, tail.col);
        errors++;
      end
    end

    // Random items in three idling phases
    for (int p = 0; p < 3; p++) begin
      phase         = p;
      send_idle_pct = (p == 0) ? 19 : (p == 1) ? 48 : 0;
      recv_idle_pct = (p == 0) ? 48 : (p == 1) ? 19 : 0;
      for (int k = 0; k < RandomItems / 3; k++) begin
        pick = $urandom_range(99);
        if (pick < 25)      ch = ChTab;
        else if (pick < 37) ch = ChBs;
        else if (pick < 45) ch = ChCr;
        else if (pick < 60) ch = CharW'($urandom_range(31));
        else                ch = CharW'($urandom_range(255));
        cmd = ($urandom_range(99) < 10) ? CmdSpare : CmdW'($urandom_range(2));
        dev = ($urandom_range(99) < 8) ? DevNone : DevW'($urandom_range(NumDevices - 1));
        offer_item(cmd, dev, ch, n, tail);
      end
    end

    // Drain, then allow for any stray bytes
    in_bus.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("console_output_column_tracker: match");
    end else begin
      $display("console_output_column_tracker: mismatch");
    end
    $finish;
  end

endmodule
